// ----- rtl/core/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hierarchical timer wheel
// Beat payloads, command classes, result kinds, slot states and engine states.
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;

    // Slot status codes
    localparam logic [1:0] STAT_FREE   = 2'd0;
    localparam logic [1:0] STAT_PEND   = 2'd1;
    localparam logic [1:0] STAT_ERASED = 2'd2;

    // Empty marker for list links and bucket head/tail
    localparam logic [6:0] NIL = 7'd64;

    // Far-distance clamp
    localparam logic [47:0] DIST_CLAMP = 48'h0000_ffff_ffff;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  slot;
        logic [47:0] first_expiry;
        logic [31:0] period;
        logic        exact;
        logic [47:0] now;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  slot_res;
        logic [47:0] fire_time;
        logic        last;
    } out_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_CANCEL,
        OP_TICK,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  slot;
        logic [47:0] first_expiry;
        logic [31:0] period;
        logic        exact;
        logic [47:0] now;
    } cmd_t;

    typedef enum logic [4:0] {
        ENG_INIT,
        ENG_IDLE,
        ENG_CHK,
        ENG_RESP,
        ENG_PL1,
        ENG_PL2,
        ENG_PL3,
        ENG_PL4,
        ENG_TICK,
        ENG_CAS_RD,
        ENG_CAS_HD,
        ENG_CAS_CHK,
        ENG_CAS_GOT,
        ENG_DR_RD,
        ENG_DR_HD,
        ENG_DR_CHK,
        ENG_DR_GOT,
        ENG_DR_FIRE,
        ENG_DR_R2,
        ENG_DR_END
    } eng_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/htw_front.sv -----
// ----------------------------------------------------------------------------
// htw_front: command intake
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_front #(
    parameter int TIMER_SLOTS = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          init_done,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire htw_pkg::in_t  s_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output htw_pkg::cmd_t      q_data
);

    htw_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    htw_pkg::cmd_t cls;
    logic          push, pop;
    logic          slot_ok;

    assign slot_ok = ({1'b0, s_data.slot} < 7'(TIMER_SLOTS));

    // Classify the incoming beat
    always_comb begin
        cls.slot         = s_data.slot;
        cls.first_expiry = s_data.first_expiry;
        cls.period       = s_data.period;
        cls.exact        = s_data.exact;
        cls.now          = s_data.now;
        case (s_data.func)
            htw_pkg::FUNC_START: begin
                cls.op = slot_ok ? htw_pkg::OP_START : htw_pkg::OP_REJECT;
            end
            htw_pkg::FUNC_CANCEL: begin
                cls.op = slot_ok ? htw_pkg::OP_CANCEL : htw_pkg::OP_REJECT;
            end
            htw_pkg::FUNC_TICK: cls.op = htw_pkg::OP_TICK;
            default:            cls.op = htw_pkg::OP_REJECT;
        endcase
    end

    assign s_ready = init_done && (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the classified beat
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/htw_engine.sv -----
// ----------------------------------------------------------------------------
// htw_engine: timer wheel execution unit
// Owns wheel time, bucket and slot memories; runs start, cancel and tick.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_engine #(
    parameter int ROOT_BITS   = 8,
    parameter int LEVEL_BITS  = 6,
    parameter int TIMER_SLOTS = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    output logic               init_done,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire htw_pkg::cmd_t q_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output htw_pkg::out_t      m_data
);

    localparam int R        = ROOT_BITS;
    localparam int L        = LEVEL_BITS;
    localparam int ROOT_SZ  = 1 << R;
    localparam int LVL_SZ   = 1 << L;
    localparam int NB       = ROOT_SZ + 4 * LVL_SZ;
    localparam int BW       = $clog2(NB);
    localparam int SW       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int BASE3    = ROOT_SZ + 3 * LVL_SZ;

    // Memories
    logic [13:0] bkt_mem  [NB];
    logic [6:0]  link_mem [TIMER_SLOTS];
    logic [47:0] exp_mem  [TIMER_SLOTS];
    logic [31:0] per_mem  [TIMER_SLOTS];
    logic        exa_mem  [TIMER_SLOTS];
    logic [1:0]  st_mem   [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] st_vld_reg;

    logic          bkt_we;
    logic [BW-1:0] bkt_wa, bkt_ra;
    logic [13:0]   bkt_wd, bkt_rd_reg;
    logic          link_we;
    logic [SW-1:0] link_wa;
    logic [6:0]    link_wd, link_rd_reg;
    logic          exp_we;
    logic [SW-1:0] exp_wa;
    logic [47:0]   exp_wd, exp_rd_reg;
    logic          per_we;
    logic [31:0]   per_rd_reg;
    logic          exa_rd_reg;
    logic          st_we;
    logic [SW-1:0] st_wa;
    logic [1:0]    st_wd, st_rd_reg;
    logic [SW-1:0] slot_ra;

    // Control and datapath registers
    htw_pkg::eng_state_t state_reg, state_next;
    htw_pkg::eng_state_t ret_reg, ret_next;
    htw_pkg::cmd_t       cmd_reg, cmd_next;
    logic [47:0]   wt_reg, wt_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [1:0]    kind_reg, kind_next;
    logic [47:0]   pl_ex_reg, pl_ex_next;
    logic [SW-1:0] pl_slot_reg, pl_slot_next;
    logic [BW-1:0] pl_b_reg, pl_b_next;
    logic [6:0]    pl_tail_reg, pl_tail_next;
    logic [47:0]   d_reg, d_next;
    logic [47:0]   clamp_reg, clamp_next;
    logic [6:0]    cur_reg, cur_next;
    logic [6:0]    guard_reg, guard_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [47:0]   nx_reg, nx_next;
    logic [47:0]   nowp_reg, nowp_next;
    logic          exa_sv_reg, exa_sv_next;
    logic          held_reg, held_next;
    logic [5:0]    held_slot_reg, held_slot_next;
    logic          out_valid_reg, out_valid_next;
    htw_pkg::out_t out_reg, out_next;

    // Derived conditions
    logic          can_push, cur_ok, cas_more, bkt_empty;
    logic [L-1:0]  cidx;
    logic [BW-1:0] cas_b, place_b;
    logic [47:0]   ex_far, ex_new;
    logic [6:0]    bkt_head, bkt_tail;

    assign init_done = (state_reg != htw_pkg::ENG_INIT);
    assign q_ready   = (state_reg == htw_pkg::ENG_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign can_push  = !out_valid_reg || m_ready;
    assign cur_ok    = (cur_reg < 7'(TIMER_SLOTS)) && (guard_reg < 7'(TIMER_SLOTS));
    assign bkt_head  = bkt_rd_reg[13:7];
    assign bkt_tail  = bkt_rd_reg[6:0];
    assign bkt_empty = (bkt_head == htw_pkg::NIL) || (bkt_tail >= 7'(TIMER_SLOTS));

    // Select the cascade index of the current upper level
    always_comb begin
        case (lvl_reg)
            2'd0:    cidx = wt_reg[R+L-1:R];
            2'd1:    cidx = wt_reg[R+2*L-1:R+L];
            2'd2:    cidx = wt_reg[R+3*L-1:R+2*L];
            default: cidx = wt_reg[R+4*L-1:R+3*L];
        endcase
    end

    assign cas_b    = BW'(ROOT_SZ) + (BW'(lvl_reg) << L) + BW'(cidx);
    assign cas_more = (cidx == '0) && (lvl_reg != 2'd3);

    // Pick the bucket for a placement from the registered distance
    assign ex_far = (|d_reg[47:32]) ? clamp_reg : pl_ex_reg;
    always_comb begin
        if (d_reg[47:R] == '0) begin
            place_b = BW'(pl_ex_reg[R-1:0]);
        end else if (d_reg[47:R+L] == '0) begin
            place_b = BW'(ROOT_SZ) + BW'(pl_ex_reg[R+L-1:R]);
        end else if (d_reg[47:R+2*L] == '0) begin
            place_b = BW'(ROOT_SZ + LVL_SZ) + BW'(pl_ex_reg[R+2*L-1:R+L]);
        end else if (d_reg[47:R+3*L] == '0) begin
            place_b = BW'(ROOT_SZ + 2 * LVL_SZ) + BW'(pl_ex_reg[R+3*L-1:R+2*L]);
        end else if (d_reg[47]) begin
            place_b = BW'(wt_reg[R-1:0]);
        end else begin
            place_b = BW'(BASE3) + BW'(ex_far[R+4*L-1:R+3*L]);
        end
    end

    // Reschedule: strict cadence, or resync a late inexact timer to now plus its period
    assign ex_new = (!exa_sv_reg && (cmd_reg.now >= nx_reg)) ? nowp_reg : nx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            htw_pkg::ENG_INIT: begin
                if (clr_reg == BW'(NB - 1)) state_next = htw_pkg::ENG_IDLE;
            end
            htw_pkg::ENG_IDLE: begin
                if (q_valid) begin
                    case (q_data.op)
                        htw_pkg::OP_START, htw_pkg::OP_CANCEL: state_next = htw_pkg::ENG_CHK;
                        htw_pkg::OP_TICK: state_next = htw_pkg::ENG_TICK;
                        default:          state_next = htw_pkg::ENG_RESP;
                    endcase
                end
            end
            htw_pkg::ENG_CHK: begin
                if (cmd_reg.op == htw_pkg::OP_START && st_rd_reg == htw_pkg::STAT_FREE) begin
                    state_next = htw_pkg::ENG_PL1;
                end else begin
                    state_next = htw_pkg::ENG_RESP;
                end
            end
            htw_pkg::ENG_RESP: begin
                if (can_push) state_next = htw_pkg::ENG_IDLE;
            end
            htw_pkg::ENG_PL1: state_next = htw_pkg::ENG_PL2;
            htw_pkg::ENG_PL2: state_next = htw_pkg::ENG_PL3;
            htw_pkg::ENG_PL3: state_next = bkt_empty ? ret_reg : htw_pkg::ENG_PL4;
            htw_pkg::ENG_PL4: state_next = ret_reg;
            htw_pkg::ENG_TICK: begin
                if (cmd_reg.now == wt_reg) begin
                    state_next = htw_pkg::ENG_IDLE;
                end else if (wt_reg[R-1:0] == '0) begin
                    state_next = htw_pkg::ENG_CAS_RD;
                end else begin
                    state_next = htw_pkg::ENG_DR_RD;
                end
            end
            htw_pkg::ENG_CAS_RD:  state_next = htw_pkg::ENG_CAS_HD;
            htw_pkg::ENG_CAS_HD:  state_next = htw_pkg::ENG_CAS_CHK;
            htw_pkg::ENG_CAS_CHK: begin
                if (cur_ok) begin
                    state_next = htw_pkg::ENG_CAS_GOT;
                end else if (cas_more) begin
                    state_next = htw_pkg::ENG_CAS_RD;
                end else begin
                    state_next = htw_pkg::ENG_DR_RD;
                end
            end
            htw_pkg::ENG_CAS_GOT: state_next = htw_pkg::ENG_PL1;
            htw_pkg::ENG_DR_RD:   state_next = htw_pkg::ENG_DR_HD;
            htw_pkg::ENG_DR_HD:   state_next = htw_pkg::ENG_DR_CHK;
            htw_pkg::ENG_DR_CHK: begin
                state_next = cur_ok ? htw_pkg::ENG_DR_GOT : htw_pkg::ENG_DR_END;
            end
            htw_pkg::ENG_DR_GOT: begin
                state_next = (st_rd_reg == htw_pkg::STAT_PEND) ? htw_pkg::ENG_DR_FIRE
                                                               : htw_pkg::ENG_DR_CHK;
            end
            htw_pkg::ENG_DR_FIRE: begin
                if (!held_reg || can_push) state_next = htw_pkg::ENG_DR_R2;
            end
            htw_pkg::ENG_DR_R2: state_next = htw_pkg::ENG_PL1;
            htw_pkg::ENG_DR_END: begin
                if (!held_reg || can_push) state_next = htw_pkg::ENG_IDLE;
            end
            default: state_next = htw_pkg::ENG_IDLE;
        endcase
    end

    // Datapath, memory controls and result beats
    always_comb begin
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        wt_next        = wt_reg;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        pl_ex_next     = pl_ex_reg;
        pl_slot_next   = pl_slot_reg;
        pl_b_next      = pl_b_reg;
        pl_tail_next   = pl_tail_reg;
        d_next         = d_reg;
        clamp_next     = clamp_reg;
        cur_next       = cur_reg;
        guard_next     = guard_reg;
        lvl_next       = lvl_reg;
        nx_next        = nx_reg;
        nowp_next      = nowp_reg;
        exa_sv_next    = exa_sv_reg;
        held_next      = held_reg;
        held_slot_next = held_slot_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        bkt_we  = 1'b0;
        bkt_wa  = pl_b_reg;
        bkt_wd  = {htw_pkg::NIL, htw_pkg::NIL};
        bkt_ra  = pl_b_reg;
        link_we = 1'b0;
        link_wa = pl_slot_reg;
        link_wd = htw_pkg::NIL;
        exp_we  = 1'b0;
        exp_wa  = pl_slot_reg;
        exp_wd  = ex_new;
        per_we  = 1'b0;
        st_we   = 1'b0;
        st_wa   = pl_slot_reg;
        st_wd   = htw_pkg::STAT_FREE;
        slot_ra = pl_slot_reg;

        case (state_reg)
            // Sweep the bucket memory to empty after reset
            htw_pkg::ENG_INIT: begin
                bkt_we   = 1'b1;
                bkt_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            htw_pkg::ENG_IDLE: begin
                slot_ra = q_data.slot[SW-1:0];
                if (q_valid) begin
                    cmd_next     = q_data;
                    pl_slot_next = q_data.slot[SW-1:0];
                    kind_next    = htw_pkg::KIND_REJECT;
                    held_next    = 1'b0;
                    lvl_next     = 2'd0;
                end
            end
            htw_pkg::ENG_CHK: begin
                if (cmd_reg.op == htw_pkg::OP_START) begin
                    if (st_rd_reg == htw_pkg::STAT_FREE) begin
                        exp_we     = 1'b1;
                        exp_wd     = cmd_reg.first_expiry;
                        per_we     = 1'b1;
                        st_we      = 1'b1;
                        st_wd      = htw_pkg::STAT_PEND;
                        pl_ex_next = cmd_reg.first_expiry;
                        ret_next   = htw_pkg::ENG_RESP;
                        kind_next  = htw_pkg::KIND_ACCEPT;
                    end
                end else if (st_rd_reg == htw_pkg::STAT_PEND) begin
                    st_we     = 1'b1;
                    st_wd     = htw_pkg::STAT_ERASED;
                    kind_next = htw_pkg::KIND_ACCEPT;
                end
            end
            htw_pkg::ENG_RESP: begin
                if (can_push) begin
                    out_valid_next     = 1'b1;
                    out_next.kind      = kind_reg;
                    out_next.slot_res  = cmd_reg.slot;
                    out_next.fire_time = '0;
                    out_next.last      = 1'b1;
                end
            end
            // Placement: distance, bucket pick, append
            htw_pkg::ENG_PL1: begin
                d_next     = pl_ex_reg - wt_reg;
                clamp_next = wt_reg + htw_pkg::DIST_CLAMP;
            end
            htw_pkg::ENG_PL2: begin
                bkt_ra    = place_b;
                pl_b_next = place_b;
            end
            htw_pkg::ENG_PL3: begin
                bkt_we       = 1'b1;
                bkt_wd       = {bkt_empty ? 7'(pl_slot_reg) : bkt_head, 7'(pl_slot_reg)};
                link_we      = 1'b1;
                link_wd      = htw_pkg::NIL;
                pl_tail_next = bkt_tail;
            end
            htw_pkg::ENG_PL4: begin
                link_we = 1'b1;
                link_wa = pl_tail_reg[SW-1:0];
                link_wd = 7'(pl_slot_reg);
            end
            // Cascade: detach an upper bucket and re-place its slots
            htw_pkg::ENG_CAS_RD: begin
                bkt_ra = cas_b;
                bkt_we = 1'b1;
                bkt_wa = cas_b;
            end
            htw_pkg::ENG_CAS_HD: begin
                cur_next   = bkt_head;
                guard_next = '0;
            end
            htw_pkg::ENG_CAS_CHK: begin
                slot_ra = cur_reg[SW-1:0];
                if (cur_ok) begin
                    pl_slot_next = cur_reg[SW-1:0];
                    guard_next   = guard_reg + 1'b1;
                end else if (cas_more) begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            htw_pkg::ENG_CAS_GOT: begin
                cur_next   = link_rd_reg;
                pl_ex_next = exp_rd_reg;
                ret_next   = htw_pkg::ENG_CAS_CHK;
            end
            // Drain: detach the root bucket and walk it in list order
            htw_pkg::ENG_DR_RD: begin
                bkt_ra = BW'(wt_reg[R-1:0]);
                bkt_we = 1'b1;
                bkt_wa = BW'(wt_reg[R-1:0]);
            end
            htw_pkg::ENG_DR_HD: begin
                cur_next   = bkt_head;
                guard_next = '0;
            end
            htw_pkg::ENG_DR_CHK: begin
                slot_ra = cur_reg[SW-1:0];
                if (cur_ok) begin
                    pl_slot_next = cur_reg[SW-1:0];
                    guard_next   = guard_reg + 1'b1;
                end
            end
            htw_pkg::ENG_DR_GOT: begin
                cur_next    = link_rd_reg;
                nx_next     = exp_rd_reg + 48'(per_rd_reg);
                nowp_next   = cmd_reg.now + 48'(per_rd_reg);
                exa_sv_next = exa_rd_reg;
                if (st_rd_reg != htw_pkg::STAT_PEND) begin
                    st_we = 1'b1;
                    st_wd = htw_pkg::STAT_FREE;
                end
            end
            // Hold one fire beat back so the final one can carry last
            htw_pkg::ENG_DR_FIRE: begin
                if (!held_reg || can_push) begin
                    if (held_reg) begin
                        out_valid_next     = 1'b1;
                        out_next.kind      = htw_pkg::KIND_FIRED;
                        out_next.slot_res  = held_slot_reg;
                        out_next.fire_time = wt_reg;
                        out_next.last      = 1'b0;
                    end
                    held_next      = 1'b1;
                    held_slot_next = 6'(pl_slot_reg);
                end
            end
            htw_pkg::ENG_DR_R2: begin
                exp_we     = 1'b1;
                pl_ex_next = ex_new;
                ret_next   = htw_pkg::ENG_DR_CHK;
            end
            htw_pkg::ENG_DR_END: begin
                if (!held_reg || can_push) begin
                    if (held_reg) begin
                        out_valid_next     = 1'b1;
                        out_next.kind      = htw_pkg::KIND_FIRED;
                        out_next.slot_res  = held_slot_reg;
                        out_next.fire_time = wt_reg;
                        out_next.last      = 1'b1;
                    end
                    held_next = 1'b0;
                    wt_next   = wt_reg + 48'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= htw_pkg::ENG_INIT;
            wt_reg        <= '0;
            clr_reg       <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            st_vld_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            wt_reg        <= wt_next;
            clr_reg       <= clr_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (st_we) st_vld_reg[st_wa] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ret_reg       <= ret_next;
        cmd_reg       <= cmd_next;
        kind_reg      <= kind_next;
        pl_ex_reg     <= pl_ex_next;
        pl_slot_reg   <= pl_slot_next;
        pl_b_reg      <= pl_b_next;
        pl_tail_reg   <= pl_tail_next;
        d_reg         <= d_next;
        clamp_reg     <= clamp_next;
        cur_reg       <= cur_next;
        guard_reg     <= guard_next;
        lvl_reg       <= lvl_next;
        nx_reg        <= nx_next;
        nowp_reg      <= nowp_next;
        exa_sv_reg    <= exa_sv_next;
        held_slot_reg <= held_slot_next;
        out_reg       <= out_next;
    end

    // Bucket head/tail memory
    always_ff @(posedge aclk) begin
        if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
        bkt_rd_reg <= bkt_mem[bkt_ra];
    end

    // Slot memories
    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        link_rd_reg <= link_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (exp_we) exp_mem[exp_wa] <= exp_wd;
        exp_rd_reg <= exp_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (per_we) begin
            per_mem[pl_slot_reg] <= cmd_reg.period;
            exa_mem[pl_slot_reg] <= cmd_reg.exact;
        end
        per_rd_reg <= per_mem[slot_ra];
        exa_rd_reg <= exa_mem[slot_ra];
    end

    // Status memory; an entry never written reads as free
    always_ff @(posedge aclk) begin
        if (st_we) st_mem[st_wa] <= st_wd;
        st_rd_reg <= st_vld_reg[slot_ra] ? st_mem[slot_ra] : htw_pkg::STAT_FREE;
    end

endmodule

`default_nettype wire

// ----- rtl/core/hierarchical_timer_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel: five-level timing wheel over a slot table
// Start, cancel and tick commands; ticks cascade upper levels and fire timers.
// ----------------------------------------------------------------------------
//  channel   direction  beat payload       handshake
//  s_        in         in_t command       s_valid / s_ready
//  m_        out        out_t result       m_valid / m_ready
//
//  After reset the bucket memory is swept empty, one entry a cycle, over all
//  2^ROOT_BITS + 4 * 2^LEVEL_BITS entries (512 by default); s_ready stays low.
//  Cancel reads the slot status; start reads it and, for a free slot, places
//  the timer through the bucket memory port; an unknown function is rejected.
//  A tick detaches buckets, re-places cascaded slots, fires and re-places
//  pending slots and frees erased ones; a tick whose now equals wheel time
//  does nothing. A stalled m_ready holds the engine at a fire.
//  A two-entry command queue lets intake run while the engine works.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_timer_wheel #(
    parameter int ROOT_BITS   = 8,
    parameter int LEVEL_BITS  = 6,
    parameter int TIMER_SLOTS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire htw_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output htw_pkg::out_t     m_data
);

    logic          init_done;
    logic          q_valid, q_ready;
    htw_pkg::cmd_t q_data;

    htw_front #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    htw_engine #(
        .ROOT_BITS   (ROOT_BITS),
        .LEVEL_BITS  (LEVEL_BITS),
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/tb_hierarchical_timer_wheel.sv -----
// ----------------------------------------------------------------------------
// tb_hierarchical_timer_wheel: self-checking bench of the timer wheel
// Drives start, cancel and tick beats, predicts every result with a local
// copy of the wheel, and compares each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hierarchical_timer_wheel;

    localparam int ROOT_BITS   = 8;
    localparam int LEVEL_BITS  = 6;
    localparam int TIMER_SLOTS = 64;
    localparam int ROOT_SIZE   = 1 << ROOT_BITS;
    localparam int LVL_SIZE    = 1 << LEVEL_BITS;
    localparam int NBUCKETS    = ROOT_SIZE + 4 * LVL_SIZE;
    localparam int WATCH_LIMIT = 20000;
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    htw_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    htw_pkg::out_t m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    // wheel shadow
    logic [47:0] w_time;
    logic [6:0]  b_head [NBUCKETS];
    logic [6:0]  b_tail [NBUCKETS];
    logic [6:0]  t_next [TIMER_SLOTS];
    logic [47:0] t_expiry [TIMER_SLOTS];
    logic [31:0] t_period [TIMER_SLOTS];
    logic        t_exact [TIMER_SLOTS];
    logic [1:0]  t_status [TIMER_SLOTS];

    htw_pkg::out_t pending_results [$];

    hierarchical_timer_wheel dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [47:0] rnd48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(1));
    endfunction

    function automatic void wheel_append(int b, int s);
        t_next[s] = htw_pkg::NIL;
        if (b_head[b] == htw_pkg::NIL || b_tail[b] >= TIMER_SLOTS) begin
            b_head[b] = s[6:0];
        end else begin
            t_next[b_tail[b]] = s[6:0];
        end
        b_tail[b] = s[6:0];
    endfunction

    function automatic void wheel_place(int s);
        logic [47:0] ex;
        logic [47:0] d;
        int b;
        ex = t_expiry[s];
        d = ex - w_time;
        if (d < (48'd1 << ROOT_BITS)) begin
            b = int'(ex[ROOT_BITS-1:0]);
        end else if (d < (48'd1 << (ROOT_BITS + LEVEL_BITS))) begin
            b = ROOT_SIZE + int'((ex >> ROOT_BITS) & (LVL_SIZE - 1));
        end else if (d < (48'd1 << (ROOT_BITS + 2 * LEVEL_BITS))) begin
            b = ROOT_SIZE + LVL_SIZE
                + int'((ex >> (ROOT_BITS + LEVEL_BITS)) & (LVL_SIZE - 1));
        end else if (d < (48'd1 << (ROOT_BITS + 3 * LEVEL_BITS))) begin
            b = ROOT_SIZE + 2 * LVL_SIZE
                + int'((ex >> (ROOT_BITS + 2 * LEVEL_BITS)) & (LVL_SIZE - 1));
        end else if (d[47]) begin
            b = int'(w_time[ROOT_BITS-1:0]);
        end else begin
            if (d > htw_pkg::DIST_CLAMP) ex = w_time + htw_pkg::DIST_CLAMP;
            b = ROOT_SIZE + 3 * LVL_SIZE
                + int'((ex >> (ROOT_BITS + 3 * LEVEL_BITS)) & (LVL_SIZE - 1));
        end
        wheel_append(b, s);
    endfunction

    function automatic int wheel_detach(int b);
        int h;
        h = int'(b_head[b]);
        b_head[b] = htw_pkg::NIL;
        b_tail[b] = htw_pkg::NIL;
        return h;
    endfunction

    function automatic int wheel_cascade(int lvl);
        int idx;
        int cur;
        int nxt;
        int guard;
        idx = int'((w_time >> (ROOT_BITS + (lvl - 1) * LEVEL_BITS)) & (LVL_SIZE - 1));
        cur = wheel_detach(ROOT_SIZE + (lvl - 1) * LVL_SIZE + idx);
        guard = 0;
        while (cur < TIMER_SLOTS && guard < TIMER_SLOTS) begin
            nxt = int'(t_next[cur]);
            wheel_place(cur);
            cur = nxt;
            guard++;
        end
        return idx;
    endfunction

    function automatic void wheel_reset();
        w_time = '0;
        for (int i = 0; i < NBUCKETS; i++) begin
            b_head[i] = htw_pkg::NIL;
            b_tail[i] = htw_pkg::NIL;
        end
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            t_next[i] = '0;
            t_expiry[i] = '0;
            t_period[i] = '0;
            t_exact[i] = 1'b0;
            t_status[i] = htw_pkg::STAT_FREE;
        end
    endfunction

    function automatic htw_pkg::out_t make_result(logic [1:0] k, int s, logic [47:0] t,
                                                  logic l);
        htw_pkg::out_t r;
        r.kind = k;
        r.slot_res = s[5:0];
        r.fire_time = t;
        r.last = l;
        return r;
    endfunction

    // Work out the results of one command beat and advance the shadow wheel.
    function automatic void predict_wheel(htw_pkg::in_t c);
        int s;
        int n;
        int cur;
        int nxt;
        int guard;
        int idx;
        logic [47:0] nx;
        s = int'(c.slot);
        n = 0;
        case (c.func)
            htw_pkg::FUNC_START: begin
                if (t_status[s] != htw_pkg::STAT_FREE) begin
                    pending_results.push_back(
                        make_result(htw_pkg::KIND_REJECT, s, '0, 1'b1));
                end else begin
                    t_expiry[s] = c.first_expiry;
                    t_period[s] = c.period;
                    t_exact[s] = c.exact;
                    t_status[s] = htw_pkg::STAT_PEND;
                    wheel_place(s);
                    pending_results.push_back(
                        make_result(htw_pkg::KIND_ACCEPT, s, '0, 1'b1));
                end
            end
            htw_pkg::FUNC_CANCEL: begin
                if (t_status[s] != htw_pkg::STAT_PEND) begin
                    pending_results.push_back(
                        make_result(htw_pkg::KIND_REJECT, s, '0, 1'b1));
                end else begin
                    t_status[s] = htw_pkg::STAT_ERASED;
                    pending_results.push_back(
                        make_result(htw_pkg::KIND_ACCEPT, s, '0, 1'b1));
                end
            end
            htw_pkg::FUNC_TICK: begin
                if (c.now != w_time) begin
                    idx = int'(w_time[ROOT_BITS-1:0]);
                    if (idx == 0 && wheel_cascade(1) == 0 && wheel_cascade(2) == 0
                        && wheel_cascade(3) == 0)
                        void'(wheel_cascade(4));
                    cur = wheel_detach(idx);
                    guard = 0;
                    while (cur < TIMER_SLOTS && guard < TIMER_SLOTS) begin
                        nxt = int'(t_next[cur]);
                        guard++;
                        if (t_status[cur] != htw_pkg::STAT_PEND) begin
                            t_status[cur] = htw_pkg::STAT_FREE;
                        end else begin
                            pending_results.push_back(
                                make_result(htw_pkg::KIND_FIRED, cur, w_time, 1'b0));
                            n++;
                            nx = t_expiry[cur] + {16'd0, t_period[cur]};
                            if (!t_exact[cur] && c.now >= nx)
                                nx = c.now + {16'd0, t_period[cur]};
                            t_expiry[cur] = nx;
                            wheel_place(cur);
                        end
                        cur = nxt;
                    end
                    w_time = w_time + 48'd1;
                    if (n > 0) pending_results[$].last = 1'b1;
                end
            end
            default: begin
                pending_results.push_back(make_result(htw_pkg::KIND_REJECT, s, '0, 1'b1));
            end
        endcase
    endfunction

    // Send one command beat, with random idle cycles ahead of it.
    // Valid stays high after acceptance only until the next call in the same step.
    task automatic send_cmd(htw_pkg::in_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        predict_wheel(c);
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic htw_pkg::in_t cmd(logic [1:0] f, int s, logic [47:0] fx,
                                         logic [31:0] p, logic e, logic [47:0] nw);
        htw_pkg::in_t c;
        c.func = f;
        c.slot = s[5:0];
        c.first_expiry = fx;
        c.period = p;
        c.exact = e;
        c.now = nw;
        return c;
    endfunction

    task automatic tick_cmd(logic [47:0] nw);
        send_cmd(cmd(htw_pkg::FUNC_TICK, int'($urandom_range(63)), rnd48(),
                     $urandom, rbit(), nw));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Directed: rejects, cancels, past, far and clamped starts, fires.
    task automatic test_directed();
        send_cmd(cmd(htw_pkg::FUNC_START, 0, 48'd3, 32'd5, 1'b1, '0));
        send_cmd(cmd(htw_pkg::FUNC_START, 0, 48'd3, 32'd5, 1'b1, '0));
        send_cmd(cmd(htw_pkg::FUNC_START, 63, 48'hffff_ffff_ffff, 32'hffff_ffff, 1'b0, '0));
        send_cmd(cmd(htw_pkg::FUNC_START, 1, 48'h7fff_ffff_ffff, 32'd1, 1'b0, '1));
        send_cmd(cmd(htw_pkg::FUNC_START, 2, 48'd300, 32'd2, 1'b0, '0));
        send_cmd(cmd(htw_pkg::FUNC_START, 3, 48'd20000, 32'd7, 1'b1, '0));
        send_cmd(cmd(htw_pkg::FUNC_START, 4, 48'd3, 32'd4, 1'b0, '0));
        send_cmd(cmd(htw_pkg::FUNC_CANCEL, 4, '0, 32'd1, 1'b0, '0));
        send_cmd(cmd(htw_pkg::FUNC_CANCEL, 4, '0, 32'd1, 1'b0, '0));
        send_cmd(cmd(htw_pkg::FUNC_CANCEL, 9, '0, 32'd1, 1'b0, '0));
        send_cmd(cmd(FUNC_UNKNOWN, 5, '1, 32'd1, 1'b1, '1));
        tick_cmd(48'd0);
        for (int i = 0; i < 6; i++) tick_cmd(48'd100);
        tick_cmd(48'd5);
        tick_cmd(48'hffff_ffff_ffff);
        send_cmd(cmd(htw_pkg::FUNC_START, 4, 48'd2, 32'd1, 1'b1, '0));
        for (int i = 0; i < 4; i++) tick_cmd(48'd1);
        wait_drained();
    endtask

    // Random: mostly near starts, some cancels, many ticks with random now.
    task automatic test_random(int count);
        int r;
        logic [47:0] fx;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                case ($urandom_range(3))
                    0: fx = w_time + 48'($urandom_range(12));
                    1: fx = w_time + 48'($urandom_range(400));
                    2: fx = w_time - 48'($urandom_range(20));
                    default: fx = rnd48();
                endcase
                send_cmd(cmd(htw_pkg::FUNC_START, int'($urandom_range(15)), fx,
                             ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 12),
                             rbit(), rnd48()));
            end else if (r < 45) begin
                send_cmd(cmd(htw_pkg::FUNC_CANCEL, int'($urandom_range(15)), rnd48(),
                             $urandom, rbit(), rnd48()));
            end else if (r < 47) begin
                send_cmd(cmd(FUNC_UNKNOWN, int'($urandom_range(63)), rnd48(),
                             $urandom, rbit(), rnd48()));
            end else begin
                tick_cmd(($urandom_range(3) == 0) ? rnd48()
                                                  : w_time + 48'($urandom_range(1, 9)));
            end
        end
    endtask

    // Check each result beat against the oldest prediction.
    always @(posedge aclk) begin
        htw_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // Randomly stall the result channel.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Count cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        wheel_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 10;
        recv_idle_pct = 77;
        test_directed();
        test_random(50);
        wait_drained();
        send_idle_pct = 77;
        recv_idle_pct = 10;
        test_random(50);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(45);
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
